FILE: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared codes and control types for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_INVALID = 1'b1;

    // Per-cycle command broadcast to every cell of the sorted row
    typedef struct packed {
        logic insert;   // a transaction enters the row this cycle
        logic clear;    // drop every held entry
        logic full;     // window is full: the oldest entry leaves
        logic new_bad;  // entering sample is marked invalid
    } swm_ctl_t;

endpackage

FILE: hw/rtl/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted row: holds an entry and its age, and on each insert
// keeps it, takes a neighbor's entry, or takes the new sample.
// ----------------------------------------------------------------------------
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int AGE_W        = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  swm_ctl_t                ctl,
    input  logic [SAMPLE_WIDTH-1:0] new_val,
    input  logic [AGE_W-1:0]        last_age,
    input  logic                    left_ev,
    input  logic                    left_used,
    input  logic                    left_bad,
    input  logic [SAMPLE_WIDTH-1:0] left_val,
    input  logic [AGE_W-1:0]        left_age,
    input  logic                    left_lt,
    input  logic                    right_used,
    input  logic                    right_bad,
    input  logic [SAMPLE_WIDTH-1:0] right_val,
    input  logic [AGE_W-1:0]        right_age,
    input  logic                    right_lt,
    output logic                    used,
    output logic                    bad,
    output logic [SAMPLE_WIDTH-1:0] val,
    output logic [AGE_W-1:0]        age,
    output logic [SAMPLE_WIDTH:0]   key,
    output logic                    lt,
    output logic                    evict,
    output logic                    ev_seen
);

    typedef enum logic [1:0] {
        SRC_OWN,
        SRC_LEFT,
        SRC_RIGHT,
        SRC_NEW
    } src_t;

    logic                    used_reg, used_next;
    logic                    bad_reg, bad_next;
    logic [SAMPLE_WIDTH-1:0] val_reg, val_next;
    logic [AGE_W-1:0]        age_reg, age_next;
    logic [SAMPLE_WIDTH:0]   new_key;
    logic                    after;
    src_t                    src;

    // order: valid samples by signed value, then invalid ones
    assign key     = {bad_reg, ~val_reg[SAMPLE_WIDTH-1], val_reg[SAMPLE_WIDTH-2:0]};
    assign new_key = {ctl.new_bad, ~new_val[SAMPLE_WIDTH-1], new_val[SAMPLE_WIDTH-2:0]};
    assign lt      = used_reg && (key < new_key);
    assign evict   = used_reg && ctl.full && (age_reg == last_age);
    assign ev_seen = left_ev || evict;
    // cells to the right of the evicted one close the gap
    assign after   = ctl.full && left_ev;

    always_comb
    begin
        if (after)
        begin
            src = right_lt ? SRC_RIGHT : (lt ? SRC_NEW : SRC_OWN);
        end
        else if (evict)
        begin
            src = right_lt ? SRC_RIGHT : (left_lt ? SRC_NEW : SRC_LEFT);
        end
        else
        begin
            src = lt ? SRC_OWN : (left_lt ? SRC_NEW : SRC_LEFT);
        end
    end

    always_comb
    begin
        used_next = used_reg;
        bad_next  = bad_reg;
        val_next  = val_reg;
        age_next  = age_reg;
        if (ctl.clear)
        begin
            used_next = 1'b0;
        end
        else if (ctl.insert)
        begin
            case (src)
                SRC_OWN:
                begin
                    age_next = age_reg + 1'b1;
                end
                SRC_LEFT:
                begin
                    used_next = left_used;
                    bad_next  = left_bad;
                    val_next  = left_val;
                    age_next  = left_age + 1'b1;
                end
                SRC_RIGHT:
                begin
                    used_next = right_used;
                    bad_next  = right_bad;
                    val_next  = right_val;
                    age_next  = right_age + 1'b1;
                end
                default:
                begin
                    used_next = 1'b1;
                    bad_next  = ctl.new_bad;
                    val_next  = new_val;
                    age_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bad_reg <= bad_next;
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign used = used_reg;
    assign bad  = bad_reg;
    assign val  = val_reg;
    assign age  = age_reg;

endmodule

FILE: hw/rtl/swm_cell_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell_row
// Chain of cells kept in sorted order, with the evicted-key broadcast and
// the two-rank pick of the middle entries.
// ----------------------------------------------------------------------------
module swm_cell_row
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int AGE_W        = 6
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_ctl_t                       ctl,
    input  logic [SAMPLE_WIDTH-1:0]        new_val,
    input  logic [AGE_W-1:0]               last_age,
    input  logic [AGE_W-1:0]               idx_lo,
    input  logic [AGE_W-1:0]               idx_hi,
    output logic                           ev_bad,
    output logic signed [SAMPLE_WIDTH-1:0] lo_val,
    output logic signed [SAMPLE_WIDTH-1:0] hi_val
);

    logic                    used_q [MAX_WINDOW];
    logic                    bad_q  [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] val_q  [MAX_WINDOW];
    logic [AGE_W-1:0]        age_q  [MAX_WINDOW];
    logic [SAMPLE_WIDTH:0]   key_q  [MAX_WINDOW];
    logic                    lt_q   [MAX_WINDOW];
    logic                    ev_q   [MAX_WINDOW];
    logic                    seen_q [MAX_WINDOW];
    logic [SAMPLE_WIDTH:0]   ev_key;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                    l_ev, l_used, l_bad, l_lt, r_used, r_bad, r_lt;
        logic [SAMPLE_WIDTH-1:0] l_val, r_val;
        logic [AGE_W-1:0]        l_age, r_age;

        if (i == 0)
        begin : g_first
            assign l_ev   = 1'b0;
            assign l_used = 1'b0;
            assign l_bad  = 1'b0;
            assign l_val  = '0;
            assign l_age  = '0;
            assign l_lt   = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_ev   = seen_q[i-1];
            assign l_used = used_q[i-1];
            assign l_bad  = bad_q[i-1];
            assign l_val  = val_q[i-1];
            assign l_age  = age_q[i-1];
            assign l_lt   = lt_q[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign r_used = 1'b0;
            assign r_bad  = 1'b0;
            assign r_val  = '0;
            assign r_age  = '0;
            assign r_lt   = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_used = used_q[i+1];
            assign r_bad  = bad_q[i+1];
            assign r_val  = val_q[i+1];
            assign r_age  = age_q[i+1];
            assign r_lt   = lt_q[i+1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_W        (AGE_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_val    (new_val),
            .last_age   (last_age),
            .left_ev    (l_ev),
            .left_used  (l_used),
            .left_bad   (l_bad),
            .left_val   (l_val),
            .left_age   (l_age),
            .left_lt    (l_lt),
            .right_used (r_used),
            .right_bad  (r_bad),
            .right_val  (r_val),
            .right_age  (r_age),
            .right_lt   (r_lt),
            .used       (used_q[i]),
            .bad        (bad_q[i]),
            .val        (val_q[i]),
            .age        (age_q[i]),
            .key        (key_q[i]),
            .lt         (lt_q[i]),
            .evict      (ev_q[i]),
            .ev_seen    (seen_q[i])
        );
    end

    always_comb
    begin
        ev_key = '0;
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (ev_q[i])
            begin
                ev_key = ev_key | key_q[i];
            end
            if (AGE_W'(i) == idx_lo)
            begin
                lo_val = lo_val | val_q[i];
            end
            if (AGE_W'(i) == idx_hi)
            begin
                hi_val = hi_val | val_q[i];
            end
        end
    end

    assign ev_bad = ev_key[SAMPLE_WIDTH];

endmodule

FILE: hw/rtl/sliding_window_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median
// Median of the valid samples among the most recent window_length samples,
// kept as a sorted row of cells that evict the oldest entry and insert the
// new one in the same cycle.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata: sample; tuser: sample_invalid
//  m_axis    out        m_axis_tvalid/tready    tdata: median, valid_count;
//                                               tuser: median_invalid
//  cfg       in         cfg_we                  cfg_index, cfg_data
//
//  One transaction per cycle while s_axis_tready is high; a result is
//  presented once the output register loads it from the cell row.
//  The cell row updates at the input edge; the output register reads the
//  two middle ranks and averages them once the output stage may load.
//  Reset empties the window; length resets to MAX_WINDOW, no clearing pass.
//  A stalled output holds one result plus one sample in the row, then
//  s_axis_tready drops.
// ----------------------------------------------------------------------------
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16,
    localparam int LEN_W       = $clog2(MAX_WINDOW + 1),
    localparam int AGE_W       = $clog2(MAX_WINDOW),
    localparam int IN_W        = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W       = ((SAMPLE_WIDTH + LEN_W + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // [SW-1:0] sample, rest zero
    input  logic                 s_axis_tuser,   // [0] sample_invalid
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // median, valid_count, zero pad
    output logic                 m_axis_tuser,   // [0] median_invalid
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    logic [LEN_W-1:0]        wl_reg, wl_next;
    logic                    ign_reg, ign_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic [LEN_W-1:0]        inv_reg, inv_next;
    logic                    pend_reg, pend_next;
    logic                    oval_reg, oval_next;
    logic [SAMPLE_WIDTH-1:0] med_reg, med_next;
    logic                    mbad_reg, mbad_next;
    logic [LEN_W-1:0]        cnt_reg, cnt_next;

    logic                           accept;
    logic                           out_load;
    logic                           full;
    logic                           ev_bad;
    logic [LEN_W-1:0]               len_sat;
    logic [LEN_W-1:0]               nv;
    logic [LEN_W-1:0]               nv_m1;
    logic [AGE_W-1:0]               idx_lo, idx_hi;
    logic signed [SAMPLE_WIDTH-1:0] lo_val, hi_val;
    logic signed [SAMPLE_WIDTH:0]   sum;
    swm_ctl_t                       ctl;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = !oval_reg || m_axis_tready;
    assign s_axis_tready = !pend_reg || out_load;
    assign full          = (fill_reg == wl_reg);

    assign ctl.insert  = accept && !cfg_we;
    assign ctl.clear   = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
    assign ctl.full    = full;
    assign ctl.new_bad = s_axis_tuser;

    assign nv     = fill_reg - inv_reg;
    assign nv_m1  = nv - LEN_W'(1);
    assign idx_lo = AGE_W'(nv_m1 >> 1);
    assign idx_hi = AGE_W'(nv >> 1);

    swm_cell_row #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AGE_W        (AGE_W)
    ) u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .new_val  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .last_age (AGE_W'(wl_reg - LEN_W'(1))),
        .idx_lo   (idx_lo),
        .idx_hi   (idx_hi),
        .ev_bad   (ev_bad),
        .lo_val   (lo_val),
        .hi_val   (hi_val)
    );

    assign sum = {lo_val[SAMPLE_WIDTH-1], lo_val} + {hi_val[SAMPLE_WIDTH-1], hi_val};

    always_comb
    begin
        if (cfg_data == '0)
        begin
            len_sat = LEN_W'(1);
        end
        else if (cfg_data > LEN_W'(MAX_WINDOW))
        begin
            len_sat = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len_sat = cfg_data;
        end
    end

    always_comb
    begin
        wl_next   = wl_reg;
        ign_next  = ign_reg;
        fill_next = fill_reg;
        inv_next  = inv_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:
                begin
                    wl_next   = len_sat;
                    fill_next = '0;
                    inv_next  = '0;
                end
                REG_IGNORE_INVALID:
                begin
                    ign_next = cfg_data[0];
                end
                default:
                begin
                    wl_next = wl_reg;
                end
            endcase
        end
        else if (accept)
        begin
            if (!full)
            begin
                fill_next = fill_reg + LEN_W'(1);
            end
            inv_next = inv_reg + LEN_W'(s_axis_tuser) - LEN_W'(full && ev_bad);
        end
    end

    always_comb
    begin
        pend_next = accept || (pend_reg && !out_load);
        oval_next = out_load ? pend_reg : oval_reg;
        med_next  = med_reg;
        mbad_next = mbad_reg;
        cnt_next  = cnt_reg;
        if (out_load && pend_reg)
        begin
            mbad_next = (nv == '0) || (ign_reg && (inv_reg != '0));
            med_next  = mbad_next ? '0 : sum[SAMPLE_WIDTH:1];
            cnt_next  = nv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= LEN_W'(MAX_WINDOW);
            ign_reg  <= 1'b0;
            fill_reg <= '0;
            inv_reg  <= '0;
            pend_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            wl_reg   <= wl_next;
            ign_reg  <= ign_next;
            fill_reg <= fill_next;
            inv_reg  <= inv_next;
            pend_reg <= pend_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        med_reg  <= med_next;
        mbad_reg <= mbad_next;
        cnt_reg  <= cnt_next;
    end

    assign m_axis_tvalid = oval_reg;
    assign m_axis_tuser  = mbad_reg;
    assign m_axis_tdata  = OUT_W'({cnt_reg, med_reg});

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= wl_reg)
        else $error("fill count beyond window length");

    a_inv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inv_reg <= fill_reg)
        else $error("invalid count beyond fill count");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !out_load) |-> !s_axis_tready)
        else $error("input taken while row result is blocked");

    a_pend_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_reg)
        else $error("accepted transaction lost before output stage");

endmodule

FILE: sim/sliding_window_median_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Self-checking bench for the sliding window median filter: a directed run
// over the sample extremes, invalid samples, ignore mode and saturated window
// lengths, then random phases under changing window settings. A scoreboard
// keeps its own window model, sorts the valid samples held and checks every
// median, invalid flag and valid count in order, with random gaps on the
// input stream and random back-pressure on the output stream.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
    import swm_pkg::*;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int LEN_W        = 7;
    localparam int IN_W         = 16;
    localparam int OUT_W        = 24;
    localparam int TARGET_ITEMS = 2000;
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] median;
        logic                    bad;
        logic [LEN_W-1:0]        count;
    } median_result_t;

    class median_scoreboard;
        logic signed [SAMPLE_WIDTH-1:0] ring_val [MAX_WINDOW];
        bit                             ring_bad [MAX_WINDOW];
        int                             oldest;
        int                             fill;
        int                             bad_held;
        int                             win_len;
        bit                             ignore_bad;
        median_result_t                 pending_q [$];
        int                             checked;
        int                             errors;

        function new();
            oldest     = 0;
            fill       = 0;
            bad_held   = 0;
            win_len    = MAX_WINDOW;
            ignore_bad = 0;
            checked    = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
            if (idx == REG_WINDOW_LENGTH)
            begin
                win_len  = (data == 0) ? 1 : ((data > MAX_WINDOW) ? MAX_WINDOW : int'(data));
                oldest   = 0;
                fill     = 0;
                bad_held = 0;
            end
            else if (idx == REG_IGNORE_INVALID)
            begin
                ignore_bad = data[0];
            end
        endfunction

        function void take_sample(logic signed [SAMPLE_WIDTH-1:0] value, bit bad);
            int             sorted [MAX_WINDOW];
            int             n;
            int             slot;
            int             j;
            int             v;
            median_result_t r;
            if (fill < win_len)
            begin
                slot = fill;
                fill++;
            end
            else
            begin
                slot = oldest;
                if (ring_bad[slot])
                    bad_held--;
                oldest = (oldest + 1 >= win_len) ? 0 : oldest + 1;
            end
            ring_val[slot] = value;
            ring_bad[slot] = bad;
            if (bad)
                bad_held++;
            n = 0;
            for (int i = 0; i < fill; i++)
            begin
                if (!ring_bad[i])
                begin
                    v = ring_val[i];
                    j = n;
                    while (j > 0 && sorted[j-1] > v)
                    begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = v;
                    n++;
                end
            end
            r.bad    = (n == 0) || (ignore_bad && bad_held > 0);
            r.count  = n[LEN_W-1:0];
            r.median = '0;
            if (!r.bad)
            begin
                if (n % 2)
                    v = sorted[n/2];
                else
                    v = (sorted[n/2-1] + sorted[n/2]) >>> 1;
                r.median = v[SAMPLE_WIDTH-1:0];
            end
            pending_q.push_back(r);
        endfunction

        function void check_median(logic [SAMPLE_WIDTH-1:0] median, logic bad,
                                   logic [LEN_W-1:0] count);
            median_result_t exp_r;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: unexpected result median=%0d invalid=%0b count=%0d",
                             $signed(median), bad, count);
                return;
            end
            exp_r = pending_q.pop_front();
            checked++;
            if (median !== exp_r.median || bad !== exp_r.bad || count !== exp_r.count)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: result %0d: expected median=%0d invalid=%0b count=%0d,",
                             checked, $signed(exp_r.median), exp_r.bad, exp_r.count,
                             " got median=%0d invalid=%0b count=%0d",
                             $signed(median), bad, count);
            end
        endfunction

        function bit busy();
            return pending_q.size() != 0;
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [LEN_W-1:0]     cfg_data      = '0;

    median_scoreboard sb = new();
    bit               calm = 1'b1;
    int               quiet_cycles = 0;
    int               stall_left = 0;
    int               samples_sent = 0;
    int               invalid_sent = 0;
    int               settings_written = 0;

    sliding_window_median uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // output back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left--;
        else if (m_axis_tready && !calm && $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = pause_len() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_median(m_axis_tdata[SAMPLE_WIDTH-1:0], m_axis_tuser,
                            m_axis_tdata[SAMPLE_WIDTH +: LEN_W]);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("sliding_window_median regression: fail");
        $finish;
    end

    task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] value, input bit bad);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pause_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= bad;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        sb.take_sample(value, bad);
        samples_sent++;
        if (bad)
            invalid_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (sb.busy())
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        settings_written++;
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return (($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000)
                      ^ (($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000);
            1, 2, 3: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_window();
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return LEN_W'($urandom_range(1, 4));
            2: return LEN_W'($urandom_range(5, 63));
            3: return 7'd64;
            4: return LEN_W'($urandom_range(65, 127));
            default: return LEN_W'($urandom_range(1, 16));
        endcase
    endfunction

    initial
    begin
        int n_items;
        int bad_pct;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty window, extremes, even-count floor, ignore mode
        push_sample(16'h1234, 1'b1);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h5555, 1'b1);
        push_sample(16'h0001, 1'b0);
        write_reg(REG_IGNORE_INVALID, 7'd1);
        push_sample(16'h0005, 1'b0);
        write_reg(REG_WINDOW_LENGTH, 7'd0);
        push_sample(16'hAAAA, 1'b1);
        push_sample(16'h0007, 1'b0);
        write_reg(REG_WINDOW_LENGTH, 7'd2);
        push_sample(16'h0000, 1'b1);
        push_sample(16'd100, 1'b0);
        push_sample(-16'sd100, 1'b0);
        push_sample(-16'sd101, 1'b0);
        write_reg(REG_IGNORE_INVALID, 7'd126);
        write_reg(REG_WINDOW_LENGTH, 7'd127);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h7FFF, 1'b0);
        write_reg(REG_WINDOW_LENGTH, 7'd64);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h8001, 1'b0);

        // random phases
        while (samples_sent < TARGET_ITEMS)
        begin
            calm = 1'b1;
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_WINDOW_LENGTH, pick_window());
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_IGNORE_INVALID, LEN_W'($urandom_range(0, 127)));
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: bad_pct = 0;
                1: bad_pct = 5;
                2: bad_pct = 30;
                default: bad_pct = 80;
            endcase
            n_items = $urandom_range(20, 150);
            repeat (n_items)
                push_sample(pick_sample(), $urandom_range(0, 99) < bad_pct);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.busy())
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d samples (%0d invalid) across %0d register writes.",
                 samples_sent, invalid_sent, settings_written);
        $display("Checked %0d medians, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && !sb.busy())
            $display("sliding_window_median regression: pass");
        else
            $display("sliding_window_median regression: fail");
        $finish;
    end

endmodule
